### rtl/single_wire_humidity_sensor_reader_assert.svh
// Assertion macros shared by the checker of the humidity sensor reader.
`ifndef SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH
`define SINGLE_WIRE_HUMIDITY_SENSOR_READER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while reset is held.
`define SWHR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while reset is held.
`define SWHR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/swhr_pkg.sv
// Types and constants shared by the humidity sensor reader modules.
`timescale 1ns / 1ps

package swhr_pkg;

    localparam int FRAME_BITS   = 40;
    localparam int BITS_W       = $clog2(FRAME_BITS + 1);
    localparam int TICKS_W      = 16;
    localparam int RUN_W        = 9;
    localparam int EDGE_W       = 7;
    localparam int SCALED_W     = 18;
    localparam int SCALE_FACTOR = 1000;
    localparam int HANDSHAKE_EDGES = 4;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [1:0] REG_BIT_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_LIMIT    = 2'd1;
    localparam logic [1:0] REG_START_LOW_TICKS  = 2'd2;
    localparam logic [1:0] REG_START_HIGH_TICKS = 2'd3;

    localparam logic [7:0]  RST_BIT_THRESHOLD    = 8'd15;
    localparam logic [7:0]  RST_TIMEOUT_LIMIT    = 8'd255;
    localparam logic [15:0] RST_START_LOW_TICKS  = 16'd18000;
    localparam logic [7:0]  RST_START_HIGH_TICKS = 8'd40;

    // Line drive codes
    localparam logic [1:0] DRV_RELEASE = 2'd0;
    localparam logic [1:0] DRV_LOW     = 2'd1;
    localparam logic [1:0] DRV_HIGH    = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_HIGH,
        PH_LISTEN
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_CKSUM   = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  bit_threshold;
        logic [7:0]  timeout_limit;
        logic [15:0] start_low_ticks;
        logic [7:0]  start_high_ticks;
    } t_cfg;

    typedef struct packed {
        logic start_req;
        logic line_level;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]          line_drive;
        logic                busy_res;
        logic                done_res;
        logic [1:0]          status;
        logic [7:0]          humidity_whole;
        logic [7:0]          humidity_frac;
        logic [7:0]          temperature_whole;
        logic [7:0]          temperature_frac;
        logic [SCALED_W-1:0] humidity_scaled;
        logic [SCALED_W-1:0] temperature_scaled;
    } t_out_beat;

endpackage

### rtl/swhr_regs.sv
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module swhr_regs import swhr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg       r_cfg;
    logic [1:0] idx;
    logic       wr_en;

    assign idx    = paddr[3:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bit_threshold    <= RST_BIT_THRESHOLD;
            r_cfg.timeout_limit    <= RST_TIMEOUT_LIMIT;
            r_cfg.start_low_ticks  <= RST_START_LOW_TICKS;
            r_cfg.start_high_ticks <= RST_START_HIGH_TICKS;
        end else if (wr_en) begin
            unique case (idx)
                REG_BIT_THRESHOLD:    r_cfg.bit_threshold    <= pwdata[7:0];
                REG_TIMEOUT_LIMIT:    r_cfg.timeout_limit    <= pwdata[7:0];
                REG_START_LOW_TICKS:  r_cfg.start_low_ticks  <= pwdata[15:0];
                REG_START_HIGH_TICKS: r_cfg.start_high_ticks <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_BIT_THRESHOLD:    prdata = {24'd0, r_cfg.bit_threshold};
            REG_TIMEOUT_LIMIT:    prdata = {24'd0, r_cfg.timeout_limit};
            REG_START_LOW_TICKS:  prdata = {16'd0, r_cfg.start_low_ticks};
            REG_START_HIGH_TICKS: prdata = {24'd0, r_cfg.start_high_ticks};
            default:              prdata = '0;
        endcase
    end

endmodule

### rtl/swhr_seq.sv
// Tick sequencer: drive phases, edge timing, bit capture and checksum.
`timescale 1ns / 1ps

module swhr_seq import swhr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_beat  i_in,
    input  t_cfg      i_cfg,
    output t_out_beat o_result
);

    t_phase                r_phase,       n_phase;
    logic [TICKS_W-1:0]    r_phase_ticks, n_phase_ticks;
    logic                  r_prev,        n_prev;
    logic [EDGE_W-1:0]     r_edge,        n_edge;
    logic [RUN_W-1:0]      r_run,         n_run;
    logic [BITS_W-1:0]     r_bits,        n_bits;
    logic [FRAME_BITS-1:0] r_frame,       n_frame;
    logic [31:0]           r_stored,      n_stored;
    t_status               r_status,      n_status;

    logic       v_used;
    logic       v_done;
    logic [1:0] v_drive;
    logic [7:0] v_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_phase_ticks <= '0;
            r_prev        <= 1'b1;
            r_edge        <= '0;
            r_run         <= '0;
            r_bits        <= '0;
            r_frame       <= '0;
            r_stored      <= '0;
            r_status      <= ST_OK;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_phase_ticks <= n_phase_ticks;
            r_prev        <= n_prev;
            r_edge        <= n_edge;
            r_run         <= n_run;
            r_bits        <= n_bits;
            r_frame       <= n_frame;
            r_stored      <= n_stored;
            r_status      <= n_status;
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_phase_ticks = r_phase_ticks;
        n_prev        = r_prev;
        n_edge        = r_edge;
        n_run         = r_run;
        n_bits        = r_bits;
        n_frame       = r_frame;
        n_stored      = r_stored;
        n_status      = r_status;
        v_used        = 1'b0;
        v_done        = 1'b0;
        v_drive       = DRV_RELEASE;
        v_sum         = '0;

        if (r_phase == PH_IDLE && i_in.start_req) begin
            n_phase       = PH_LOW;
            n_phase_ticks = '0;
        end

        if (n_phase == PH_LOW) begin
            if (n_phase_ticks >= i_cfg.start_low_ticks) begin
                n_phase       = PH_HIGH;
                n_phase_ticks = '0;
            end else begin
                v_drive       = DRV_LOW;
                n_phase_ticks = n_phase_ticks + 1'b1;
                v_used        = 1'b1;
            end
        end

        if (!v_used && n_phase == PH_HIGH) begin
            if (n_phase_ticks >= {8'd0, i_cfg.start_high_ticks}) begin
                n_phase       = PH_LISTEN;
                n_phase_ticks = '0;
                n_prev        = 1'b1;
                n_edge        = '0;
                n_run         = '0;
                n_bits        = '0;
                n_frame       = '0;
            end else begin
                v_drive       = DRV_HIGH;
                n_phase_ticks = n_phase_ticks + 1'b1;
                v_used        = 1'b1;
            end
        end

        if (!v_used && n_phase == PH_LISTEN) begin
            if (i_in.line_level == n_prev) begin
                // level held: count, saturating, and check the limit
                if (n_run != {RUN_W{1'b1}}) begin
                    n_run = n_run + 1'b1;
                end
                if (n_run > {1'b0, i_cfg.timeout_limit}) begin
                    n_phase  = PH_IDLE;
                    n_status = ST_TIMEOUT;
                    v_done   = 1'b1;
                end
            end else begin
                // past the handshake, a falling edge closes a high phase
                if (n_edge >= EDGE_W'(HANDSHAKE_EDGES) && !n_edge[0]
                        && n_bits < BITS_W'(FRAME_BITS)) begin
                    n_frame = {n_frame[FRAME_BITS-2:0], n_run >= {1'b0, i_cfg.bit_threshold}};
                    n_bits  = n_bits + 1'b1;
                end
                if (n_bits >= BITS_W'(FRAME_BITS)) begin
                    v_sum = n_frame[39:32] + n_frame[31:24] + n_frame[23:16] + n_frame[15:8];
                    if (v_sum != n_frame[7:0]) begin
                        n_status = ST_CKSUM;
                    end else begin
                        n_stored = n_frame[FRAME_BITS-1:8];
                        n_status = ST_OK;
                    end
                    n_phase = PH_IDLE;
                    v_done  = 1'b1;
                end else begin
                    n_prev = i_in.line_level;
                    if (n_edge != {EDGE_W{1'b1}}) begin
                        n_edge = n_edge + 1'b1;
                    end
                    n_run = RUN_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_result.line_drive         = v_drive;
        o_result.busy_res           = (n_phase != PH_IDLE);
        o_result.done_res           = v_done;
        o_result.status             = n_status;
        o_result.humidity_whole     = n_stored[31:24];
        o_result.humidity_frac      = n_stored[23:16];
        o_result.temperature_whole  = n_stored[15:8];
        o_result.temperature_frac   = n_stored[7:0];
        o_result.humidity_scaled    = SCALED_W'(n_stored[31:24]) * SCALED_W'(SCALE_FACTOR)
                                      + SCALED_W'(n_stored[23:16]);
        o_result.temperature_scaled = SCALED_W'(n_stored[15:8]) * SCALED_W'(SCALE_FACTOR)
                                      + SCALED_W'(n_stored[7:0]);
    end

endmodule

### rtl/single_wire_humidity_sensor_reader.sv
// Top level of the single-wire humidity and temperature sensor reader.
//
//   channel   direction  handshake                      beat
//   in        inbound    i_in_valid / o_in_stall        one microsecond tick
//   out       outbound   o_out_valid / i_out_stall      one result per tick
//   config    inbound    psel / penable / pwrite        one register write
//
// Every input beat yields exactly one result beat. An input beat is taken every cycle
// unless the input side stalls; the sequencer state and the output register advance on the
// same edge, so the result shows in the cycle after its tick is accepted.
// Reset is synchronous, active low: it clears the sequencer state, the status and
// the stored reading, and loads the register defaults.
// While a result waits on a stalled output, the input side stalls too; no beat is lost.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader import swhr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // tick input
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in,
    // result output
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg      cfg;
    t_out_beat result;
    logic      step;

    t_out_beat r_out;
    logic      r_out_valid;

    // Hold the input whenever the output register is full and not being drained.
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign step        = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    swhr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Advance the sequencer by one tick per accepted beat.
    swhr_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Output register: load on every accepted tick, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

endmodule

### rtl/swhr_chk.sv
// Port-level checker for the humidity sensor reader, bound to the top level.
`timescale 1ns / 1ps
`include "single_wire_humidity_sensor_reader_assert.svh"

module swhr_chk import swhr_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out
);

    `SWHR_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out), "stalled result beat changed")
    `SWHR_ASSERT_NOW(a_stall_back, o_out_valid && i_out_stall, o_in_stall, "tick taken over a stalled full output")
    `SWHR_ASSERT_NOW(a_done_idle, o_out_valid && o_out.done_res, !o_out.busy_res, "reading finished but still busy")
    `SWHR_ASSERT_NOW(a_drive_busy, o_out_valid && o_out.line_drive != DRV_RELEASE, o_out.busy_res && !o_out.done_res, "line driven outside a reading")

endmodule

bind single_wire_humidity_sensor_reader swhr_chk u_chk (.*);

### tb/single_wire_humidity_sensor_reader_checker.sv
// Tick-by-tick model of the sensor reader that checks every result beat of the block.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_checker import swhr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  t_in_beat          i_in,
    input  logic              i_out_valid,
    input  logic              i_out_stall,
    input  t_out_beat         i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic              i_pready,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output int                o_mismatches,
    output int                o_results_due,
    output logic              o_reader_busy
);

    t_cfg                  regs;
    t_phase                rd_phase;
    logic [TICKS_W-1:0]    drive_ticks;
    logic                  line_was;
    logic [EDGE_W-1:0]     edges_seen;
    logic [RUN_W-1:0]      level_run;
    logic [BITS_W-1:0]     bits_in;
    logic [FRAME_BITS-1:0] frame_bits;
    logic [31:0]           kept_reading;
    t_status               last_code;
    t_out_beat             tick_results[$];
    int                    mismatch_total = 0;

    // Advance the reader by one microsecond tick and return the beat it shows.
    function automatic t_out_beat advance_reader(input t_in_beat beat);
        t_out_beat  res;
        logic [1:0] drive;
        logic       finished;
        logic       consumed;
        logic [7:0] sum;
        int         hw, hf, tw, tf;
        drive    = DRV_RELEASE;
        finished = 1'b0;
        consumed = 1'b0;
        if (rd_phase == PH_IDLE && beat.start_req) begin
            rd_phase    = PH_LOW;
            drive_ticks = '0;
        end
        if (rd_phase == PH_LOW) begin
            if (drive_ticks >= regs.start_low_ticks) begin
                rd_phase    = PH_HIGH;
                drive_ticks = '0;
            end else begin
                drive       = DRV_LOW;
                drive_ticks = drive_ticks + 1'b1;
                consumed    = 1'b1;
            end
        end
        if (!consumed && rd_phase == PH_HIGH) begin
            if (drive_ticks >= {8'd0, regs.start_high_ticks}) begin
                rd_phase    = PH_LISTEN;
                drive_ticks = '0;
                line_was    = 1'b1;
                edges_seen  = '0;
                level_run   = '0;
                bits_in     = '0;
                frame_bits  = '0;
            end else begin
                drive       = DRV_HIGH;
                drive_ticks = drive_ticks + 1'b1;
                consumed    = 1'b1;
            end
        end
        if (!consumed && rd_phase == PH_LISTEN) begin
            if (beat.line_level == line_was) begin
                if (level_run != '1)
                    level_run = level_run + 1'b1;
                if (level_run > {1'b0, regs.timeout_limit}) begin
                    last_code = ST_TIMEOUT;
                    rd_phase  = PH_IDLE;
                    finished  = 1'b1;
                end
            end else begin
                // even-numbered changes past the handshake close a high phase
                if (edges_seen >= EDGE_W'(HANDSHAKE_EDGES) && !edges_seen[0]
                        && bits_in < BITS_W'(FRAME_BITS)) begin
                    frame_bits = {frame_bits[FRAME_BITS-2:0],
                                  level_run >= {1'b0, regs.bit_threshold}};
                    bits_in    = bits_in + 1'b1;
                end
                if (bits_in >= BITS_W'(FRAME_BITS)) begin
                    sum = frame_bits[39:32] + frame_bits[31:24] + frame_bits[23:16]
                        + frame_bits[15:8];
                    if (sum != frame_bits[7:0]) begin
                        last_code = ST_CKSUM;
                    end else begin
                        kept_reading = frame_bits[39:8];
                        last_code    = ST_OK;
                    end
                    rd_phase = PH_IDLE;
                    finished = 1'b1;
                end else begin
                    line_was = beat.line_level;
                    if (edges_seen != '1)
                        edges_seen = edges_seen + 1'b1;
                    level_run = RUN_W'(1);
                end
            end
        end
        hw = int'(kept_reading[31:24]);
        hf = int'(kept_reading[23:16]);
        tw = int'(kept_reading[15:8]);
        tf = int'(kept_reading[7:0]);
        res.line_drive         = drive;
        res.busy_res           = (rd_phase != PH_IDLE);
        res.done_res           = finished;
        res.status             = last_code;
        res.humidity_whole     = hw[7:0];
        res.humidity_frac      = hf[7:0];
        res.temperature_whole  = tw[7:0];
        res.temperature_frac   = tf[7:0];
        res.humidity_scaled    = SCALED_W'(hw * SCALE_FACTOR + hf);
        res.temperature_scaled = SCALED_W'(tw * SCALE_FACTOR + tf);
        return res;
    endfunction

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_total++;
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat due;
        if (!i_rst_n) begin
            regs.bit_threshold    = RST_BIT_THRESHOLD;
            regs.timeout_limit    = RST_TIMEOUT_LIMIT;
            regs.start_low_ticks  = RST_START_LOW_TICKS;
            regs.start_high_ticks = RST_START_HIGH_TICKS;
            rd_phase     = PH_IDLE;
            drive_ticks  = '0;
            line_was     = 1'b1;
            edges_seen   = '0;
            level_run    = '0;
            bits_in      = '0;
            frame_bits   = '0;
            kept_reading = '0;
            last_code    = ST_OK;
            tick_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_BIT_THRESHOLD:    regs.bit_threshold    = i_pwdata[7:0];
                    REG_TIMEOUT_LIMIT:    regs.timeout_limit    = i_pwdata[7:0];
                    REG_START_LOW_TICKS:  regs.start_low_ticks  = i_pwdata[15:0];
                    REG_START_HIGH_TICKS: regs.start_high_ticks = i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (tick_results.size() == 0) begin
                    mismatch_total++;
                    $display("%0t: result beat expected none actual %h", $time, i_out);
                end else begin
                    due = tick_results.pop_front();
                    check_field("line_drive", 32'(due.line_drive), 32'(i_out.line_drive));
                    check_field("busy_res", 32'(due.busy_res), 32'(i_out.busy_res));
                    check_field("done_res", 32'(due.done_res), 32'(i_out.done_res));
                    check_field("status", 32'(due.status), 32'(i_out.status));
                    check_field("humidity_whole", 32'(due.humidity_whole),
                                32'(i_out.humidity_whole));
                    check_field("humidity_frac", 32'(due.humidity_frac),
                                32'(i_out.humidity_frac));
                    check_field("temperature_whole", 32'(due.temperature_whole),
                                32'(i_out.temperature_whole));
                    check_field("temperature_frac", 32'(due.temperature_frac),
                                32'(i_out.temperature_frac));
                    check_field("humidity_scaled", 32'(due.humidity_scaled),
                                32'(i_out.humidity_scaled));
                    check_field("temperature_scaled", 32'(due.temperature_scaled),
                                32'(i_out.temperature_scaled));
                end
            end
            if (i_in_valid && !i_in_stall)
                tick_results.push_back(advance_reader(i_in));
        end
        o_mismatches  <= mismatch_total;
        o_results_due <= tick_results.size();
        o_reader_busy <= (rd_phase != PH_IDLE);
    end

endmodule

### tb/single_wire_humidity_sensor_reader_tb.sv
// Stimulus and verdict for the single-wire humidity sensor reader.
`timescale 1ns / 1ps

module single_wire_humidity_sensor_reader_tb;
    import swhr_pkg::*;

    // Longest stretch with no beat on either channel before the run is abandoned.
    // The worst honest case is the receiver hold-off plus a drain and four
    // register writes, so this leaves a wide margin.
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MODE_TICKS      = 80;

    typedef enum int {
        RD_GOOD,
        RD_BAD_SUM,
        RD_TIMEOUT,
        RD_NOISE
    } t_reading_kind;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_beat          tick_beat   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_beat         o_out;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [DATA_W-1:0] pwdata      = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int   mismatches;
    int   results_due;
    logic reader_busy;

    // Idling odds in percent; the receiver's is read by its own process, so it
    // only ever changes through a nonblocking write.
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   ticks_sent    = 0;
    int   idle_cycles   = 0;
    int   hold_left     = 0;
    logic hold_go       = 1'b0;
    logic hold_taken    = 1'b0;

    // Register values last written, so the line waveform can be timed to them.
    int thr_set  = int'(RST_BIT_THRESHOLD);
    int lim_set  = int'(RST_TIMEOUT_LIMIT);
    int low_set  = int'(RST_START_LOW_TICKS);
    int high_set = int'(RST_START_HIGH_TICKS);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    single_wire_humidity_sensor_reader i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (tick_beat),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    single_wire_humidity_sensor_reader_checker i_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (tick_beat),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_mismatches (mismatches),
        .o_results_due(results_due),
        .o_reader_busy(reader_busy)
    );

    // Receiver: stall at random, except for one long hold-off that the stimulus
    // arms once. The hold-off is counted here so the sender keeps offering
    // ticks meanwhile and the block has to push back on its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_go && !hold_taken) begin
            hold_taken  <= 1'b1;
            hold_left   <= HOLD_OFF_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: give up once neither channel has moved a beat for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one tick and hold it until the block takes it. Random gaps go in
    // front; the payload is scrambled while valid is low.
    task automatic send_tick(input logic req, input logic lvl);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            tick_beat  <= t_in_beat'(2'($urandom));
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        tick_beat.start_req  <= req;
        tick_beat.line_level <= lvl;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent++;
    endtask

    // Drop valid and wait until every result beat owed has come back.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
    endtask

    // Bring the reader back to idle: drain, then keep the line high until any
    // reading still under way times out.
    task automatic quiesce();
        drain_results();
        while (reader_busy) begin
            send_tick(1'b0, 1'b1);
            drain_results();
        end
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all four registers with the reader idle. Junk in the upper data
    // bits must be ignored by the block.
    task automatic set_regs(input int thr, input int lim, input int low, input int high);
        quiesce();
        reg_write(REG_BIT_THRESHOLD, {24'($urandom), 8'(thr)});
        reg_write(REG_TIMEOUT_LIMIT, {24'($urandom), 8'(lim)});
        reg_write(REG_START_LOW_TICKS, {16'($urandom), 16'(low)});
        reg_write(REG_START_HIGH_TICKS, {24'($urandom), 8'(high)});
        thr_set  = thr;
        lim_set  = lim;
        low_set  = low;
        high_set = high;
    endtask

    // Pick a level duration, clipped so that it never trips the timeout.
    function automatic int span(input int lo, input int hi);
        int n;
        n = $urandom_range(hi, lo);
        if (n > lim_set)
            n = lim_set;
        return n;
    endfunction

    // Hold the line at one level; now and then ask for a reading while busy.
    task automatic hold(input logic lvl, input int n);
        repeat (n) send_tick($urandom_range(31) == 0, lvl);
    endtask

    // One reading as the sensor would answer it: request, drive phase, the two
    // handshake levels, then 40 low/high pairs with the high time carrying the
    // bit, closed by the falling level that samples the last bit.
    task automatic send_reading(input t_reading_kind kind);
        logic [7:0]            b [4];
        logic [7:0]            sum;
        logic [FRAME_BITS-1:0] frame;
        int                    cut;
        int                    n;
        sum = '0;
        for (int k = 0; k < 4; k++) begin
            b[k] = 8'($urandom);
            // where every one costs a long high phase, send an all-zero reading
            if (thr_set > 16)
                b[k] = '0;
            sum = sum + b[k];
        end
        if (kind == RD_BAD_SUM)
            sum = sum ^ 8'($urandom_range(255, 1));
        frame = {b[0], b[1], b[2], b[3], sum};
        cut   = (kind == RD_TIMEOUT) ? $urandom_range(FRAME_BITS - 1) : FRAME_BITS;

        send_tick(1'b1, 1'b1);
        for (int k = 1; k < low_set + high_set; k++)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        if (kind == RD_NOISE) begin
            repeat ($urandom_range(80, 10))
                send_tick($urandom_range(15) == 0, 1'($urandom_range(1)));
            return;
        end
        hold(1'b1, span(1, 2));
        hold(1'b0, span(1, 3));
        hold(1'b1, span(1, 3));
        for (int k = 0; k < FRAME_BITS; k++) begin
            if (k == cut) begin
                // sit on one level one tick past the limit
                hold(frame[FRAME_BITS-1-k], lim_set + 1);
                return;
            end
            hold(1'b0, span(1, 2));
            // zero high phases stay short under a large threshold
            if (frame[FRAME_BITS-1-k])
                n = span((thr_set < 1) ? 1 : thr_set, thr_set + 2);
            else
                n = span(1, (thr_set < 2) ? 1 : ((thr_set > 8) ? 8 : thr_set - 1));
            hold(1'b1, n);
        end
        hold(1'b0, 1);
    endtask

    // Random readings under one idling mode, with fresh small settings now
    // and then, until the tick budget of the mode is spent.
    task automatic run_mode(input int sender_pct, input int receiver_pct, input int quota);
        int first_tick;
        int roll;
        int thr;
        send_idle_pct = sender_pct;
        recv_idle_pct <= receiver_pct;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < quota) begin
            if (ticks_sent == first_tick || $urandom_range(4) == 0) begin
                thr = $urandom_range(6, 1);
                set_regs(thr,
                         ($urandom_range(3) == 0) ? 255 : $urandom_range(thr + 10, thr + 3),
                         $urandom_range(4), $urandom_range(3));
            end
            roll = $urandom_range(99);
            if (roll < 60) begin
                send_reading(RD_GOOD);
            end else if (roll < 75) begin
                send_reading(RD_BAD_SUM);
            end else if (roll < 85) begin
                send_reading(RD_TIMEOUT);
            end else begin
                send_reading(RD_NOISE);
                quiesce();
            end
            repeat ($urandom_range(2)) send_tick(1'b0, 1'b1);
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset outputs under the default settings, no request.
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);

        // Two low ticks, one high tick, then listen; a request while driving
        // is ignored and the held line times out on its second tick.
        set_regs(3, 1, 2, 1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Both drive lengths zero: the request tick is already a listen tick.
        set_regs(3, 1, 0, 0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);

        // Low phase skipped only; level changes restart the run count.
        set_regs(3, 2, 0, 2);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b1);

        // Random readings: mostly receiver idle, then mostly sender idle, then neither.
        run_mode(31, 64, MODE_TICKS);
        run_mode(64, 31, MODE_TICKS);
        run_mode(0, 0, MODE_TICKS);

        // Register extremes, each with a reading.
        set_regs(0, 255, 0, 255);
        send_reading(RD_GOOD);
        set_regs(255, 255, 3, 0);
        send_reading(RD_GOOD);
        set_regs(2, 1, 1, 1);
        send_reading(RD_BAD_SUM);
        quiesce();
        send_reading(RD_NOISE);

        // Longest low drive written, with idle ticks only.
        set_regs(4, 30, 65535, 2);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);

        // Long receiver hold-off in the middle of a reading.
        set_regs(3, 20, 2, 1);
        hold_go <= 1'b1;
        send_reading(RD_GOOD);

        // Drain, let the output settle, then give the verdict.
        quiesce();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && results_due == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
